/* hdl/mts_pkg.sv */
// Shared types and constants for the min-tracking stack.
// Used by mts_lifo, min_tracking_stack and mts_checker; depends on nothing.
`default_nettype none

package mts_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DATA_W      = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  // operation codes
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic                     func;
    logic signed [DATA_W-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic signed [DATA_W-1:0] current_min;
    logic                     is_empty;
    logic [1:0]               status;
    logic [CNT_W-1:0]         fill_level;
  } out_rsp_t;

  // top entry and depth of one stack
  typedef struct packed {
    logic [DATA_W-1:0] top;
    logic [CNT_W-1:0]  cnt;
  } lifo_view_t;

endpackage

`default_nettype wire

/* hdl/min_tracking_stack.sv */
// Top level of the min-tracking stack: request decode, two stacks, result register.
// Depends on mts_pkg and mts_lifo.
`default_nettype none

// A LIFO of signed 32-bit values that reports its minimum after every request.
// Each request is a push or a pop and gives exactly one result, in the cycle after
// it is taken. Requests are taken one per cycle back to back; the rate is set by
// the result register, which frees itself in the same cycle that the consumer
// takes its content, so the block only stalls while a finished result waits.
// Both the value stack and the stack of minima keep their top entry in flops
// and the rest in a memory with a registered read port, which is prefetched on
// every pop, so each request touches only stack tops. No clearing pass is run
// after reset: the stacks are empty and ready in the first cycle.
// A push to a full stack returns status full, a pop of an empty stack returns
// status empty; neither changes anything. popped_value is zero unless a pop
// succeeds, and current_min is zero while the stack is empty.
module min_tracking_stack (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  mts_pkg::in_req_t   in_data,
  output logic               out_valid,
  input  wire                out_stall,
  output mts_pkg::out_rsp_t  out_data
);
  import mts_pkg::*;

  lifo_view_t val_cur, val_nxt;
  lifo_view_t min_cur, min_nxt;

  logic     accept;
  logic     is_push;
  logic     val_full, val_empty;
  logic     val_push, val_pop;
  logic     min_push, min_pop;
  logic     new_min;
  out_rsp_t rsp;

  logic     out_valid_r, out_valid_nxt;
  out_rsp_t out_data_r;

  // take a request whenever the result register is free or being drained
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign is_push   = (in_data.func == FUNC_PUSH);
  assign val_full  = (val_cur.cnt == CNT_W'(STACK_DEPTH));
  assign val_empty = (val_cur.cnt == '0);

  // drop rejected requests before they reach the stacks
  assign val_push = accept && is_push && !val_full;
  assign val_pop  = accept && !is_push && !val_empty;

  // record a value as a minimum when it is at most the current one
  assign new_min  = (min_cur.cnt == '0) ||
                    (in_data.value <= $signed(min_cur.top));
  assign min_push = val_push && new_min && (min_cur.cnt != CNT_W'(STACK_DEPTH));
  assign min_pop  = val_pop && (min_cur.cnt != '0) && (val_cur.top == min_cur.top);

  mts_lifo u_val (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (val_push),
    .pop   (val_pop),
    .wdata (in_data.value),
    .cur   (val_cur),
    .nxt   (val_nxt)
  );

  mts_lifo u_min (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (min_push),
    .pop   (min_pop),
    .wdata (in_data.value),
    .cur   (min_cur),
    .nxt   (min_nxt)
  );

  // build the result from the state the request leaves behind
  always_comb begin
    rsp.popped_value = val_pop ? $signed(val_cur.top) : '0;
    rsp.fill_level   = val_nxt.cnt;
    rsp.is_empty     = (val_nxt.cnt == '0);
    rsp.current_min  = (val_nxt.cnt != '0) ? $signed(min_nxt.top) : '0;
    if (is_push && val_full) begin
      rsp.status = ST_FULL;
    end else if (!is_push && val_empty) begin
      rsp.status = ST_EMPTY;
    end else begin
      rsp.status = ST_OK;
    end
  end

  // hold the result until taken, refill it in the same cycle
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* hdl/mts_lifo.sv */
// One hardware stack: top entry in flops, lower entries in a registered-read memory.
// Depends on mts_pkg.
`default_nettype none

module mts_lifo (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         push,
  input  wire                         pop,
  input  wire  [mts_pkg::DATA_W-1:0]  wdata,
  output mts_pkg::lifo_view_t         cur,
  output mts_pkg::lifo_view_t         nxt
);
  import mts_pkg::*;

  logic [DATA_W-1:0] mem [0:STACK_DEPTH-1];
  logic [DATA_W-1:0] mem_q_r;
  logic [DATA_W-1:0] top_r, top_nxt;
  logic [DATA_W-1:0] byp_r, byp_nxt;
  logic              use_byp_r, use_byp_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  wr_cnt, rd_cnt;
  logic [DATA_W-1:0] second;

  // entry just below the top: bypass after a push, memory after a pop
  assign second = use_byp_r ? byp_r : mem_q_r;
  assign wr_cnt = cnt_r - CNT_W'(1);
  assign rd_cnt = cnt_r - CNT_W'(3);

  always_comb begin
    top_nxt     = top_r;
    byp_nxt     = byp_r;
    use_byp_nxt = use_byp_r;
    cnt_nxt     = cnt_r;
    if (push) begin
      top_nxt     = wdata;
      byp_nxt     = top_r;
      use_byp_nxt = 1'b1;
      cnt_nxt     = cnt_r + CNT_W'(1);
    end else if (pop) begin
      top_nxt     = second;
      use_byp_nxt = 1'b0;
      cnt_nxt     = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      use_byp_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      use_byp_r <= use_byp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    byp_r <= byp_nxt;
  end

  // spill the old top on push, prefetch the new second entry on pop
  always_ff @(posedge clk) begin
    if (push && (cnt_r != '0)) begin
      mem[wr_cnt[ADDR_W-1:0]] <= top_r;
    end
    if (pop) begin
      mem_q_r <= mem[rd_cnt[ADDR_W-1:0]];
    end
  end

  assign cur.top = top_r;
  assign cur.cnt = cnt_r;
  assign nxt.top = top_nxt;
  assign nxt.cnt = cnt_nxt;

endmodule

`default_nettype wire

/* hdl/mts_checker.sv */
// Port-level checks for min_tracking_stack, attached by the bind at the end.
// Depends on mts_pkg.
`default_nettype none

module mts_checker (
  input wire                clk,
  input wire                rst_n,
  input wire                in_valid,
  input wire                in_stall,
  input mts_pkg::in_req_t   in_data,
  input wire                out_valid,
  input wire                out_stall,
  input mts_pkg::out_rsp_t  out_data
);
  import mts_pkg::*;

  // every taken request shows a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("taken request produced no result");

  // fill level never exceeds the stack depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.fill_level <= CNT_W'(STACK_DEPTH)))
    else $error("fill level above stack depth");

  // an empty stack reports no minimum and a zero fill level
  a_empty_view: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.is_empty) |->
      ((out_data.current_min == '0) && (out_data.fill_level == '0)))
    else $error("empty stack with nonzero minimum or fill level");

  // a rejected request pops no value; a rejected push leaves a full stack, a rejected pop an empty one
  a_reject_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == ST_FULL || out_data.status == ST_EMPTY)) |->
      ((out_data.popped_value == '0) &&
       ((out_data.status == ST_EMPTY) ? out_data.is_empty
                                      : (out_data.fill_level == CNT_W'(STACK_DEPTH)))))
    else $error("rejected request with inconsistent result");

endmodule

bind min_tracking_stack mts_checker u_mts_checker (.*);

`default_nettype wire
